// ===== rtl/core/bale_pkg.sv =====
// shared types and codes for the bounded array list engine
package bale_pkg;

  // opcodes
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_REM_ALL = 3'd1;
  localparam logic [2:0] OP_REM_AT  = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;
  localparam logic [2:0] OP_INSERT  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // scan modes
  localparam logic [1:0] MODE_COMPACT = 2'd0;
  localparam logic [1:0] MODE_UP      = 2'd1;
  localparam logic [1:0] MODE_DOWN    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       set_st;
    logic [1:0] st;
    logic       app_wr;
    logic       set_wr;
    logic       get_rd;
    logic       get_cap;
    logic       scan_init;
    logic [1:0] mode;
    logic       scan_step;
    logic       fin;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_lt;
    logic       pos_le;
    logic       full;
    logic       done;
  } dp_sts_t;

endpackage

// ===== rtl/core/bounded_array_list_engine_top.sv =====
// Bounded array list engine: ordered list of up to CAPACITY words in one RAM.
// Append, set, errors and unknown opcodes go straight to the result; get adds a RAM
// read; remove all, remove at and insert scan the moved entries (the whole length
// for remove all), then finish; one entry moves a cycle.
// Requests are handled one at a time; a new one is accepted once the result is
// registered. Reset clears the length count and control state; the store is not cleared.
module bounded_array_list_engine_top #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], position[9:3], element_value[41:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], read_value[33:2], list_length[40:34]
);
  import bale_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [1:0]  res_status;
  logic [31:0] res_read_value;
  logic [6:0]  res_list_length;

  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bale_dp #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_tdata[2:0]),
    .in_position     (in_tdata[9:3]),
    .in_element_value(in_tdata[41:10]),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (res_status),
    .out_read_value  (res_read_value),
    .out_list_length (res_list_length)
  );

  assign out_tdata = {7'b0, res_list_length, res_read_value, res_status};

endmodule

// ===== rtl/core/bale_ram.sv =====
// generic single write, single read ram with registered read data
module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bale_dp.sv =====
// datapath: entry store, length count, scan pointers and result registers
module bale_dp #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_opcode,
  input  logic [6:0]        in_position,
  input  logic [31:0]       in_element_value,
  input  bale_pkg::dp_cmd_t cmd,
  output bale_pkg::dp_sts_t sts,
  output logic [1:0]        out_status,
  output logic [31:0]       out_read_value,
  output logic [6:0]        out_list_length
);
  import bale_pkg::*;

  localparam int EW   = ELEMENT_WIDTH;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic [2:0]    op_r, op_nxt;
  logic [6:0]    pos_r, pos_nxt;
  logic [EW-1:0] key_r, key_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [31:0]   rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pend_r, pend_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [31:0]   ord_r, ord_nxt;
  logic [6:0]    olen_r, olen_nxt;

  logic [CMPW-1:0]  pos_x;
  logic [CMPW-1:0]  cnt_x;
  logic [CW-1:0]    pos_c;
  logic [EW+31:0]   key_ext;
  logic [EW+31:0]   rdata_ext;
  logic [CW+6:0]    len_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic          scan_wr;

  bale_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_x     = CMPW'(pos_r);
  assign cnt_x     = CMPW'(count_r);
  assign pos_c     = pos_x[CW-1:0];
  assign key_ext   = {{EW{1'b0}}, in_element_value};
  assign rdata_ext = {32'b0, ram_rdata};
  assign len_ext   = {7'b0, count_r};

  assign sts.op     = op_r;
  assign sts.pos_lt = pos_x < cnt_x;
  assign sts.pos_le = pos_x <= cnt_x;
  assign sts.full   = count_r == CW'(CAPACITY);
  assign sts.done   = (rem_r == '0) && !pend_r;

  // compaction drops entries that match the key
  assign scan_wr = cmd.scan_step && pend_r &&
                   ((mode_r != MODE_COMPACT) || (ram_rdata != key_r));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = rptr_r[AW-1:0];
    if (cmd.app_wr) begin
      ram_we = 1'b1;
    end
    if (cmd.set_wr || (cmd.fin && (mode_r == MODE_DOWN))) begin
      ram_we    = 1'b1;
      ram_waddr = pos_c[AW-1:0];
    end
    if (cmd.get_rd) begin
      ram_re    = 1'b1;
      ram_raddr = pos_c[AW-1:0];
    end
    if (cmd.scan_step) begin
      ram_re = rem_r != '0;
    end
    if (scan_wr) begin
      ram_we    = 1'b1;
      ram_waddr = wptr_r[AW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    op_nxt    = op_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    st_nxt    = st_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    mode_nxt  = mode_r;
    ost_nxt   = ost_r;
    ord_nxt   = ord_r;
    olen_nxt  = olen_r;
    if (cmd.load) begin
      op_nxt  = in_opcode;
      pos_nxt = in_position;
      key_nxt = key_ext[EW-1:0];
      st_nxt  = ST_OK;
      rd_nxt  = '0;
    end
    if (cmd.set_st) begin
      st_nxt = cmd.st;
    end
    if (cmd.app_wr) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.get_cap) begin
      rd_nxt = rdata_ext[31:0];
    end
    if (cmd.scan_init) begin
      mode_nxt = cmd.mode;
      pend_nxt = 1'b0;
      case (cmd.mode)
        MODE_UP: begin
          rem_nxt  = count_r - pos_c - 1'b1;
          rptr_nxt = pos_c + 1'b1;
          wptr_nxt = pos_c;
        end
        MODE_DOWN: begin
          rem_nxt  = count_r - pos_c;
          rptr_nxt = count_r - 1'b1;
          wptr_nxt = count_r;
        end
        default: begin
          rem_nxt  = count_r;
          rptr_nxt = '0;
          wptr_nxt = '0;
        end
      endcase
    end
    if (cmd.scan_step) begin
      pend_nxt = rem_r != '0;
      if (rem_r != '0) begin
        rem_nxt  = rem_r - 1'b1;
        rptr_nxt = (mode_r == MODE_DOWN) ? rptr_r - 1'b1 : rptr_r + 1'b1;
      end
      if (scan_wr) begin
        wptr_nxt = (mode_r == MODE_DOWN) ? wptr_r - 1'b1 : wptr_r + 1'b1;
      end
    end
    if (cmd.fin) begin
      case (mode_r)
        MODE_UP:   count_nxt = count_r - 1'b1;
        MODE_DOWN: count_nxt = count_r + 1'b1;
        default:   count_nxt = wptr_r;
      endcase
    end
    if (cmd.emit) begin
      ost_nxt  = st_r;
      ord_nxt  = rd_r;
      olen_nxt = len_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    op_r   <= op_nxt;
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    st_r   <= st_nxt;
    rd_r   <= rd_nxt;
    rptr_r <= rptr_nxt;
    wptr_r <= wptr_nxt;
    rem_r  <= rem_nxt;
    mode_r <= mode_nxt;
    ost_r  <= ost_nxt;
    ord_r  <= ord_nxt;
    olen_r <= olen_nxt;
  end

  assign out_status      = ost_r;
  assign out_read_value  = ord_r;
  assign out_list_length = olen_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_wr |-> !sts.full)
    else $error("append write into a full list");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && (mode_r == MODE_COMPACT)) |-> (wptr_r <= rptr_r))
    else $error("compaction write pointer passed read pointer");

endmodule

// ===== rtl/core/bale_ctrl.sv =====
// controller state machine sequencing each request through the datapath
module bale_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bale_pkg::dp_sts_t sts,
  output bale_pkg::dp_cmd_t cmd
);
  import bale_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_GET    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       slot_free;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = ovalid_r;
  assign slot_free  = !ovalid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMIT;
        case (sts.op)
          OP_APPEND: begin
            if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
            end else begin
              cmd.app_wr = 1'b1;
            end
          end
          OP_REM_ALL: begin
            cmd.scan_init = 1'b1;
            cmd.mode      = MODE_COMPACT;
            state_nxt     = S_SCAN;
          end
          OP_REM_AT: begin
            if (!sts.pos_lt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else begin
              cmd.scan_init = 1'b1;
              cmd.mode      = MODE_UP;
              state_nxt     = S_SCAN;
            end
          end
          OP_GET: begin
            if (!sts.pos_lt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else begin
              cmd.get_rd = 1'b1;
              state_nxt  = S_GET;
            end
          end
          OP_SET: begin
            if (!sts.pos_lt) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else begin
              cmd.set_wr = 1'b1;
            end
          end
          OP_INSERT: begin
            if (!sts.pos_le) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end else if (sts.full) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_FULL;
            end else begin
              cmd.scan_init = 1'b1;
              cmd.mode      = MODE_DOWN;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_GET: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait until the output register can take the result
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted request not decoded next cycle");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ovalid_r || out_tready))
    else $error("result emitted over a pending one");

endmodule

// ===== dv/bale_list_checker.sv =====
// checker for the bounded array list engine: shadow list, expected result queue, compare
module bale_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], position[9:3], element_value[41:10]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // status[1:0], read_value[33:2], list_length[40:34]
  output int          mismatches,
  output int          outstanding
);
  import bale_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int REPORT_CAP = 60;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  list_length;
  } list_result_t;

  logic [31:0]  shadow_entries [CAPACITY];
  int           shadow_len;
  list_result_t expected_results [$];
  int           fail_count;

  initial begin
    shadow_len  = 0;
    fail_count  = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  // applies one request to the shadow list and returns the result it should give
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t res;
    int           i;
    int           kept;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_REM_ALL: begin
        kept = 0;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_entries[i] != val) begin
            shadow_entries[kept] = shadow_entries[i];
            kept++;
          end
        end
        shadow_len = kept;
      end
      OP_REM_AT: begin
        if (int'(pos) >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < shadow_len; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_len--;
        end
      end
      OP_GET: begin
        if (int'(pos) >= shadow_len) res.status = ST_RANGE;
        else res.read_value = shadow_entries[pos];
      end
      OP_SET: begin
        if (int'(pos) >= shadow_len) res.status = ST_RANGE;
        else shadow_entries[pos] = val;
      end
      OP_INSERT: begin
        if (int'(pos) > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > int'(pos); i--)
            shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = val;
          shadow_len++;
        end
      end
      default: begin
        // unused opcodes leave the list alone
      end
    endcase
    res.list_length = 7'(shadow_len);
    return res;
  endfunction

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_list_op(in_tdata[2:0], in_tdata[9:3],
                                                 in_tdata[41:10]));
      if (out_tvalid && out_tready) begin
        got.status      = out_tdata[1:0];
        got.read_value  = out_tdata[33:2];
        got.list_length = out_tdata[40:34];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                     $time, got);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== got.status)
            report_field("status", want.status, got.status);
          if (want.read_value !== got.read_value)
            report_field("read_value", want.read_value, got.read_value);
          if (want.list_length !== got.list_length)
            report_field("list_length", want.list_length, got.list_length);
        end
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_results.size();
  end

endmodule

// ===== dv/bounded_array_list_engine_top_tb.sv =====
// stimulus and verdict for the bounded array list engine
module bounded_array_list_engine_top_tb;
  import bale_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 100;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  int          mismatches;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          cycle_count;
  int          cur_len;

  logic [31:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                  32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000};
  logic [2:0]  op_by_slot [7] = '{OP_APPEND, OP_INSERT, OP_GET, OP_SET, OP_REM_AT,
                                  OP_REM_ALL, OP_SPARE_LO};

  bounded_array_list_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bale_list_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // last reported length, only used to aim positions
  always @(posedge clk) begin
    if (!rst_n) cur_len <= 0;
    else if (out_tvalid && out_tready) cur_len <= int'(out_tdata[40:34]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // in_tvalid is lowered on idle cycles and by drain, so back to back requests keep it high
  task automatic send_req(input logic [2:0] op, input logic [6:0] pos,
                          input logic [31:0] val);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, val, pos, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value;
    if ($urandom_range(99, 0) < 60) return value_pool[$urandom_range(5, 0)];
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_pos;
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 7'($urandom_range(cur_len, 0));
    if (r < 85) return 7'(cur_len);
    if (r < 90) return 7'((cur_len == 0) ? 0 : cur_len - 1);
    return 7'($urandom_range(127, 0));
  endfunction

  // bias 0 grows the list into the full case, 2 shrinks it toward empty
  function automatic logic [2:0] pick_op(int bias);
    int cum [7];
    int r;
    int k;
    case (bias)
      0:       cum = '{35, 65, 75, 85, 93, 97, 100};
      1:       cum = '{20, 35, 50, 65, 85, 97, 100};
      default: cum = '{10, 18, 30, 40, 75, 97, 100};
    endcase
    r = $urandom_range(99, 0);
    for (k = 0; k < 6; k++)
      if (r < cum[k]) return op_by_slot[k];
    return $urandom_range(1, 0) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  initial begin
    int phase;
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list edge cases
    send_req(OP_GET,     7'd0,   32'h0000_0000);
    send_req(OP_SET,     7'd0,   32'hFFFF_FFFF);
    send_req(OP_REM_AT,  7'd0,   32'h0000_0000);
    send_req(OP_INSERT,  7'd1,   32'hFFFF_FFFF);
    send_req(OP_REM_ALL, 7'd0,   32'h0000_0000);
    // build a short list with extreme values
    send_req(OP_INSERT,  7'd0,   32'hFFFF_FFFF);
    send_req(OP_APPEND,  7'd127, 32'h0000_0000);
    send_req(OP_APPEND,  7'd0,   32'hA5A5_A5A5);
    send_req(OP_INSERT,  7'd3,   32'h5A5A_5A5A);
    send_req(OP_INSERT,  7'd127, 32'h1234_5678);
    send_req(OP_GET,     7'd0,   32'hFFFF_FFFF);
    send_req(OP_GET,     7'd3,   32'h0000_0000);
    send_req(OP_GET,     7'd4,   32'h0000_0000);
    send_req(OP_GET,     7'd127, 32'h0000_0000);
    send_req(OP_SET,     7'd1,   32'hFFFF_FFFF);
    send_req(OP_SET,     7'd4,   32'h0000_0000);
    // removes two matching entries, then one with no match
    send_req(OP_REM_ALL, 7'd0,   32'hFFFF_FFFF);
    send_req(OP_REM_ALL, 7'd0,   32'h1234_5678);
    send_req(OP_REM_AT,  7'd2,   32'h0000_0000);
    send_req(OP_REM_AT,  7'd0,   32'h0000_0000);
    send_req(OP_SPARE_LO, 7'd127, 32'hFFFF_FFFF);
    send_req(OP_SPARE_HI, 7'd0,   32'hFFFF_FFFF);
    send_req(OP_APPEND,  7'd0,   32'h8000_0001);
    send_req(OP_REM_AT,  7'd1,   32'h0000_0000);
    send_req(OP_GET,     7'd0,   32'h0000_0000);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 85; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 85; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        send_req(pick_op((n / 80) % 3), pick_pos(), pick_value());
      // hold off until every result of the phase is back
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
